FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
// Each macro expects clk_i and rst_ni in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OWO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("odometry assertion failed");

// Next-cycle implication.
`define OWO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("odometry assertion failed");

`endif

FILE: rtl/owo_pkg.sv
// ----------------------------------------------------------------------------
// owo_pkg
// Types, constants and helpers shared by the omni wheel odometry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package owo_pkg;

  typedef enum logic [2:0] {
    CFG_WHEEL_RADIUS    = 3'd0,
    CFG_INV_BODY_RADIUS = 3'd1,
    CFG_INITIAL_X       = 3'd2,
    CFG_INITIAL_Y       = 3'd3,
    CFG_INITIAL_HEADING = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    DIV_BY_THREE,
    DIV_BY_MILLION
  } div_sel_e;

  typedef enum logic [5:0] {
    BK_IDLE, BK_MUL_A, BK_MUL_B, BK_MUL_C, BK_FOLD, BK_MUL_VX, BK_MUL_OM,
    BK_DIV_VY, BK_WAIT_VY, BK_DIV_OM, BK_WAIT_OM, BK_TRIG_POSE, BK_WAIT_TRIG,
    BK_MUL_XC, BK_MUL_YS, BK_MUL_XS, BK_MUL_YC, BK_SUM_Y,
    BK_MUL_WXT, BK_DIV_X, BK_WAIT_X, BK_MUL_WYT, BK_DIV_Y, BK_WAIT_Y,
    BK_MUL_OMT, BK_DIV_H, BK_WAIT_H, BK_MUL_LO, BK_MUL_HI, BK_STEP,
    BK_TRIG_Q, BK_WAIT_Q, BK_EMIT
  } bk_state_e;

  localparam logic [29:0] InvSqrt3Q30   = 30'd619925131;
  localparam logic [29:0] CordicGainQ30 = 30'd652032874;
  localparam logic [29:0] BamPerRadian  = 30'd683565276;
  localparam int          AtanEntries   = 24;

  // Divide by 10^6 as a shift by 6 followed by a divide by 15625. The
  // reciprocals are exact for the 30-bit partial remainders of the divider.
  localparam logic [13:0] DivThree        = 14'd3;
  localparam logic [13:0] DivOddMillion   = 14'd15625;
  localparam logic [30:0] RecipThree      = 31'd349526;
  localparam logic [30:0] RecipOddMillion = 31'd1125899907;

  localparam logic [19:0] ResetWheelRadius = 20'd1966;
  localparam logic [23:0] ResetInvBodyRad  = 24'd436907;

  typedef struct packed {
    logic signed [31:0] rate_a;
    logic signed [31:0] rate_b;
    logic signed [31:0] rate_c;
    logic [31:0]        dt;
    logic               first;
  } owo_job_t;

  typedef struct packed {
    logic [19:0]        wheel_radius;
    logic [23:0]        inv_body_radius;
    logic signed [31:0] init_x;
    logic signed [31:0] init_y;
    logic [31:0]        init_heading;
  } owo_cfg_t;

  // Arctangent of 2^-i as a binary angle.
  function automatic logic [29:0] atan_bam(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    logic signed [31:0] r;
    if (x > 72'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (x < -72'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/owo_if.sv
// ----------------------------------------------------------------------------
// owo_if
// Valid/ready channels for wheel samples and pose results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface owo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] wheel_a_rate;
  logic signed [31:0] wheel_b_rate;
  logic signed [31:0] wheel_c_rate;
  logic [31:0]        stamp_us;

  modport source (output valid, wheel_a_rate, wheel_b_rate, wheel_c_rate, stamp_us,
                  input ready);
  modport sink (input valid, wheel_a_rate, wheel_b_rate, wheel_c_rate, stamp_us,
                output ready);
endinterface

interface owo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, input ready);
  modport sink (input valid, pos_x, pos_y, heading, quat_z, quat_w, output ready);
endinterface

`default_nettype wire

FILE: rtl/owo_queue.sv
// ----------------------------------------------------------------------------
// owo_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owo_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire owo_pkg::owo_job_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output owo_pkg::owo_job_t      pop_data_o,
  output logic                   empty_o
);
  import owo_pkg::*;

  owo_job_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/owo_front.sv
// ----------------------------------------------------------------------------
// owo_front
// Accept wheel samples, derive the time step and tag the first item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owo_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  owo_in_if.sink            in_i,
  output owo_pkg::owo_job_t job_o,
  output logic              push_o,
  input  wire logic         full_i
);
  import owo_pkg::*;

  logic [31:0] prev_stamp_q;
  logic        first_q;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    job_o.rate_a = in_i.wheel_a_rate;
    job_o.rate_b = in_i.wheel_b_rate;
    job_o.rate_c = in_i.wheel_c_rate;
    job_o.first  = first_q;
    // First item after reset integrates over zero time.
    job_o.dt     = first_q ? 32'd0 : in_i.stamp_us - prev_stamp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_stamp_q <= 32'd0;
      first_q      <= 1'b1;
    end else if (push_o) begin
      prev_stamp_q <= in_i.stamp_us;
      first_q      <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/owo_div.sv
// ----------------------------------------------------------------------------
// owo_div
// Signed division by 3 or 10^6, truncating toward zero. Long division in
// 16-bit digits, each by reciprocal multiplication, then a reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owo_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire owo_pkg::div_sel_e  sel_i,
  input  wire logic signed [63:0] num_i,
  output logic                    done_o,
  output logic signed [63:0]      quot_o
);
  import owo_pkg::*;

  logic [63:0] mag, num_q, quo_q;
  logic [29:0] part, part_q, rem_nx;
  logic [60:0] prod_q;
  logic [30:0] recip;
  logic [13:0] den, rem_q;
  logic [15:0] digit;
  logic        neg_q, active_q;
  div_sel_e    sel_q;
  logic [2:0]  step_q;

  assign mag    = num_i[63] ? 64'(-num_i) : 64'(num_i);
  assign den    = (sel_q == DIV_BY_THREE) ? DivThree : DivOddMillion;
  assign recip  = (sel_q == DIV_BY_THREE) ? RecipThree : RecipOddMillion;
  assign part   = {rem_q, num_q[63:48]};
  // Quotient digit: the product scaled down by 2^20 for three, 2^44 for 15625.
  assign digit  = (sel_q == DIV_BY_THREE) ? prod_q[35:20] : prod_q[59:44];
  assign rem_nx = part_q - ({14'd0, digit} * {16'd0, den});
  assign quot_o = neg_q ? -signed'(quo_q) : signed'(quo_q);

  // Even steps multiply, odd steps reduce; four digits in eight steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_o   <= 1'b0;
      step_q   <= 3'd0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        step_q   <= 3'd0;
      end else if (active_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd7) begin
          active_q <= 1'b0;
          done_o   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[63];
      sel_q <= sel_i;
      num_q <= (sel_i == DIV_BY_THREE) ? mag : (mag >> 6);
      rem_q <= 14'd0;
      quo_q <= 64'd0;
    end else if (active_q) begin
      if (!step_q[0]) begin
        part_q <= part;
        prod_q <= 61'(part) * 61'(recip);
      end else begin
        rem_q <= rem_nx[13:0];
        quo_q <= {quo_q[47:0], digit};
        num_q <= {num_q[47:0], 16'd0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/owo_cordic.sv
// ----------------------------------------------------------------------------
// owo_cordic
// Iterative rotation CORDIC: cosine and sine of a binary angle in Q3.30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owo_cordic #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [31:0]   angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  import owo_pkg::*;

  localparam int Steps = (TRIG_ITERATIONS < AtanEntries) ? TRIG_ITERATIONS : AtanEntries;
  localparam logic [4:0] LastStep = 5'(Steps - 1);

  logic signed [33:0] x_q, y_q, z_q, atan;
  logic [31:0]        rot;
  logic               flip, flip_q, active_q;
  logic [4:0]         cnt_q;

  // Fold the left half-plane onto the right one and negate at the end.
  assign flip  = (angle_i - 32'h4000_0000) < 32'h8000_0000;
  assign rot   = flip ? angle_i + 32'h8000_0000 : angle_i;
  assign atan  = signed'({4'b0, atan_bam(cnt_q)});
  assign cos_o = flip_q ? -x_q : x_q;
  assign sin_o = flip_q ? -y_q : y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_o   <= 1'b0;
      cnt_q    <= 5'd0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= 5'd0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LastStep) begin
          active_q <= 1'b0;
          done_o   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= flip;
      x_q    <= signed'({4'b0, CordicGainQ30});
      y_q    <= 34'sd0;
      z_q    <= 34'(signed'(rot));
    end else if (active_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - (y_q >>> cnt_q);
        y_q <= y_q + (x_q >>> cnt_q);
        z_q <= z_q - atan;
      end else begin
        x_q <= x_q + (y_q >>> cnt_q);
        y_q <= y_q - (x_q >>> cnt_q);
        z_q <= z_q + atan;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/owo_back.sv
// ----------------------------------------------------------------------------
// owo_back
// Sequencer over one multiplier, a serial divider and a CORDIC that folds
// wheel rates to body motion and integrates the pose.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owo_back #(
  parameter int FRACTION_BITS   = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire owo_pkg::owo_cfg_t cfg_i,
  input  wire owo_pkg::owo_job_t job_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  owo_out_if.source              out_o
);
  import owo_pkg::*;

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] r;
    logic signed [15:0] o;
    r = (35'(v) + 35'sd16384) >>> 15;
    if (r > 35'sd32767) begin
      o = 16'sh7fff;
    end else if (r < -35'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  bk_state_e state_q, state_d;

  logic signed [31:0] ra_q, rb_q, rc_q, v0_q, v1_q, v2_q, vx_q, vy_q, om_q, wx_q, wy_q;
  logic [31:0]        dt_q, heading_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic signed [33:0] c_q, s_q;
  logic signed [71:0] p_q, acc_q;
  logic signed [63:0] tmp_q;
  logic [63:0]        rad_q, lo_q, step64;
  logic signed [35:0] ma, mb;

  logic               div_start, div_done;
  div_sel_e           div_sel;
  logic signed [63:0] div_num, div_quot;
  logic               trig_start, trig_done;
  logic [31:0]        trig_angle;
  logic signed [33:0] trig_cos, trig_sin;

  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic [31:0]        out_h_q;
  logic signed [15:0] out_z_q, out_w_q;
  logic               emit;

  logic signed [32:0] diff20;
  logic signed [33:0] sum3;
  logic signed [34:0] vy_num;

  assign diff20 = 33'(v2_q) - 33'(v0_q);
  assign sum3   = 34'(v0_q) + 34'(v1_q) + 34'(v2_q);
  assign vy_num = 35'(v0_q) - (35'(v1_q) <<< 1) + 35'(v2_q);
  assign step64 = lo_q + {p_q[31:0], 32'd0};

  owo_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .sel_i   (div_sel),
    .num_i   (div_num),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  owo_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
    .clk_i, .rst_ni,
    .start_i (trig_start),
    .angle_i (trig_angle),
    .done_o  (trig_done),
    .cos_o   (trig_cos),
    .sin_o   (trig_sin)
  );

  // Next state and unit controls.
  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    ma         = 36'sd0;
    mb         = 36'sd0;
    div_start  = 1'b0;
    div_sel    = DIV_BY_MILLION;
    div_num    = p_q[63:0];
    trig_start = 1'b0;
    trig_angle = heading_q;
    emit       = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_MUL_A;
        end
      end
      BK_MUL_A: begin
        ma = 36'(ra_q); mb = signed'(36'(cfg_i.wheel_radius)); state_d = BK_MUL_B;
      end
      BK_MUL_B: begin
        ma = 36'(rb_q); mb = signed'(36'(cfg_i.wheel_radius)); state_d = BK_MUL_C;
      end
      BK_MUL_C: begin
        ma = 36'(rc_q); mb = signed'(36'(cfg_i.wheel_radius)); state_d = BK_FOLD;
      end
      BK_FOLD: state_d = BK_MUL_VX;
      BK_MUL_VX: begin
        ma = 36'(diff20); mb = signed'(36'(InvSqrt3Q30)); state_d = BK_MUL_OM;
      end
      BK_MUL_OM: begin
        ma = 36'(sum3); mb = signed'(36'(cfg_i.inv_body_radius)); state_d = BK_DIV_VY;
      end
      BK_DIV_VY: begin
        div_start = 1'b1; div_sel = DIV_BY_THREE; div_num = 64'(vy_num);
        state_d = BK_WAIT_VY;
      end
      BK_WAIT_VY: if (div_done) state_d = BK_DIV_OM;
      BK_DIV_OM: begin
        div_start = 1'b1; div_sel = DIV_BY_THREE; div_num = tmp_q;
        state_d = BK_WAIT_OM;
      end
      BK_WAIT_OM: if (div_done) state_d = BK_TRIG_POSE;
      BK_TRIG_POSE: begin
        trig_start = 1'b1; state_d = BK_WAIT_TRIG;
      end
      BK_WAIT_TRIG: if (trig_done) state_d = BK_MUL_XC;
      BK_MUL_XC: begin ma = 36'(vx_q); mb = 36'(c_q); state_d = BK_MUL_YS; end
      BK_MUL_YS: begin ma = 36'(vy_q); mb = 36'(s_q); state_d = BK_MUL_XS; end
      BK_MUL_XS: begin ma = 36'(vx_q); mb = 36'(s_q); state_d = BK_MUL_YC; end
      BK_MUL_YC: begin ma = 36'(vy_q); mb = 36'(c_q); state_d = BK_SUM_Y; end
      BK_SUM_Y: state_d = BK_MUL_WXT;
      BK_MUL_WXT: begin
        ma = 36'(wx_q); mb = signed'(36'(dt_q)); state_d = BK_DIV_X;
      end
      BK_DIV_X: begin div_start = 1'b1; state_d = BK_WAIT_X; end
      BK_WAIT_X: if (div_done) state_d = BK_MUL_WYT;
      BK_MUL_WYT: begin
        ma = 36'(wy_q); mb = signed'(36'(dt_q)); state_d = BK_DIV_Y;
      end
      BK_DIV_Y: begin div_start = 1'b1; state_d = BK_WAIT_Y; end
      BK_WAIT_Y: if (div_done) state_d = BK_MUL_OMT;
      BK_MUL_OMT: begin
        ma = 36'(om_q); mb = signed'(36'(dt_q)); state_d = BK_DIV_H;
      end
      BK_DIV_H: begin div_start = 1'b1; state_d = BK_WAIT_H; end
      BK_WAIT_H: if (div_done) state_d = BK_MUL_LO;
      // Heading step needs only the low 64 bits: split rad into two halves.
      BK_MUL_LO: begin
        ma = signed'(36'(rad_q[31:0])); mb = signed'(36'(BamPerRadian));
        state_d = BK_MUL_HI;
      end
      BK_MUL_HI: begin
        ma = signed'(36'(rad_q[63:32])); mb = signed'(36'(BamPerRadian));
        state_d = BK_STEP;
      end
      BK_STEP: state_d = BK_TRIG_Q;
      BK_TRIG_Q: begin
        trig_start = 1'b1; trig_angle = {1'b0, heading_q[31:1]}; state_d = BK_WAIT_Q;
      end
      BK_WAIT_Q: if (trig_done) state_d = BK_EMIT;
      BK_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      pos_x_q     <= 32'sd0;
      pos_y_q     <= 32'sd0;
      heading_q   <= 32'd0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BK_IDLE: begin
          if (!empty_i && job_i.first) begin
            pos_x_q   <= cfg_i.init_x;
            pos_y_q   <= cfg_i.init_y;
            heading_q <= cfg_i.init_heading;
          end
        end
        BK_WAIT_X: if (div_done) pos_x_q <= sat32(72'(pos_x_q) + 72'(div_quot));
        BK_WAIT_Y: if (div_done) pos_y_q <= sat32(72'(pos_y_q) + 72'(div_quot));
        BK_STEP:   heading_q <= heading_q + step64[FRACTION_BITS+31:FRACTION_BITS];
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    p_q <= ma * mb;
    case (state_q)
      BK_IDLE: begin
        ra_q <= job_i.rate_a;
        rb_q <= job_i.rate_b;
        rc_q <= job_i.rate_c;
        dt_q <= job_i.dt;
      end
      BK_MUL_B:   v0_q  <= sat32(p_q >>> FRACTION_BITS);
      BK_MUL_C:   v1_q  <= sat32(p_q >>> FRACTION_BITS);
      BK_FOLD:    v2_q  <= sat32(p_q >>> FRACTION_BITS);
      BK_MUL_OM:  vx_q  <= sat32(p_q >>> 30);
      BK_DIV_VY:  tmp_q <= 64'(p_q >>> FRACTION_BITS);
      BK_WAIT_VY: if (div_done) vy_q <= sat32(72'(div_quot));
      BK_WAIT_OM: if (div_done) om_q <= sat32(72'(div_quot));
      BK_WAIT_TRIG: begin
        if (trig_done) begin
          c_q <= trig_cos;
          s_q <= trig_sin;
        end
      end
      BK_MUL_YS:  acc_q <= p_q;
      BK_MUL_XS:  wx_q  <= sat32((acc_q - p_q) >>> 30);
      BK_MUL_YC:  acc_q <= p_q;
      BK_SUM_Y:   wy_q  <= sat32((acc_q + p_q) >>> 30);
      BK_WAIT_H:  if (div_done) rad_q <= div_quot;
      BK_MUL_HI:  lo_q  <= p_q[63:0];
      default: ;
    endcase
    if (emit) begin
      out_x_q <= pos_x_q;
      out_y_q <= pos_y_q;
      out_h_q <= heading_q;
      out_z_q <= to_q15(trig_sin);
      out_w_q <= to_q15(trig_cos);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pos_x   = out_x_q;
  assign out_o.pos_y   = out_y_q;
  assign out_o.heading = out_h_q;
  assign out_o.quat_z  = out_z_q;
  assign out_o.quat_w  = out_w_q;

endmodule

`default_nettype wire

FILE: rtl/omni_wheel_odometry.sv
// ----------------------------------------------------------------------------
// omni_wheel_odometry
// Dead-reckoning pose for a three-wheel omni base, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item per encoder sample: three wheel rates and a
//   microsecond stamp. out_o returns one item per input: x, y, heading and
//   the yaw quaternion (z, w). Both are valid/ready channels.
//   Write the five configuration registers through cfg_we_i/cfg_idx_i/
//   cfg_data_i while the block is idle; the initial pose is picked up by the
//   first item after reset.
// Processing:
//   One item is worked at a time in the back, with five constant divisions
//   and two CORDIC runs per item. A two-entry queue lets the front take
//   more items while the back is busy.
// Reset:
//   Clears the pose, the stamp history and the pending results and restores
//   the register defaults. The next item reloads the initial pose with dt 0.
// Back pressure:
//   A held result stays in the output register; the back finishes the next
//   item and waits, and in_i.ready drops once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module omni_wheel_odometry #(
  parameter int FRACTION_BITS   = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  owo_in_if.sink           in_i,
  owo_out_if.source        out_o
);
  import owo_pkg::*;

  owo_cfg_t cfg_q;
  owo_job_t front_job, queue_job;
  logic     push, full, pop, empty;

  // Register file; writes past the last index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_radius    <= ResetWheelRadius;
      cfg_q.inv_body_radius <= ResetInvBodyRad;
      cfg_q.init_x          <= 32'sd0;
      cfg_q.init_y          <= 32'sd0;
      cfg_q.init_heading    <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WHEEL_RADIUS:    cfg_q.wheel_radius    <= cfg_data_i[19:0];
        CFG_INV_BODY_RADIUS: cfg_q.inv_body_radius <= cfg_data_i[23:0];
        CFG_INITIAL_X:       cfg_q.init_x          <= cfg_data_i;
        CFG_INITIAL_Y:       cfg_q.init_y          <= cfg_data_i;
        CFG_INITIAL_HEADING: cfg_q.init_heading    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: accept items, derive dt, flag the first one.
  owo_front u_front (
    .clk_i, .rst_ni,
    .in_i,
    .job_o  (front_job),
    .push_o (push),
    .full_i (full)
  );

  // Decouple front and back.
  owo_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (front_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (queue_job),
    .empty_o     (empty)
  );

  // Back: kinematics, integration and the output register.
  owo_back #(
    .FRACTION_BITS   (FRACTION_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_back (
    .clk_i, .rst_ni,
    .cfg_i   (cfg_q),
    .job_i   (queue_job),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o
  );

endmodule

`default_nettype wire

FILE: rtl/owo_checker.sv
// ----------------------------------------------------------------------------
// owo_checker
// Port-level checks on item flow through the odometry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module owo_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);

  logic [2:0] pend_q;

  // Track items accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + 3'(in_valid_i && in_ready_i) - 3'(out_valid_i && out_ready_i);
    end
  end

  `OWO_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `OWO_ASSERT_IMP(a_no_orphan, out_valid_i, pend_q != 3'd0)
  `OWO_ASSERT_IMP(a_depth, 1'b1, pend_q <= 3'd4)
  `OWO_ASSERT_IMP(a_ready_idle, pend_q == 3'd0, in_ready_i)

endmodule

bind omni_wheel_odometry owo_checker u_owo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

`default_nettype wire
